// ----- hdl/gshare_predictor_with_btb_defines.svh -----
// ----------------------------------------------------------------------------
// gshare predictor assertion macros
// Shared concurrent assertion forms for the predictor and its target buffer.
// ----------------------------------------------------------------------------
`ifndef GSHARE_PREDICTOR_WITH_BTB_DEFINES_SVH
`define GSHARE_PREDICTOR_WITH_BTB_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/gpb_pkg.sv -----
// ----------------------------------------------------------------------------
// gpb_pkg
// Constants and beat types shared by the gshare predictor and its BTB.
// ----------------------------------------------------------------------------
`default_nettype none

package gpb_pkg;

   localparam int HISTORY_BITS = 4;
   localparam int PHT_ENTRIES  = 1 << HISTORY_BITS;
   localparam int BTB_ENTRIES  = 16;
   localparam int BTB_IDX_BITS = $clog2(BTB_ENTRIES);

   localparam logic [1:0] CTR_MIN       = 2'd0;
   localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
   localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
   localparam logic [1:0] CTR_MAX       = 2'd3;

   typedef struct packed {
      logic [31:0] pc;
      logic        cond_branch;
      logic        taken;
      logic [31:0] branch_target;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        predicted_taken;
      logic        btb_hit;
   } rsp_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] target;
   } btb_lookup_type;

   typedef struct packed {
      logic        en;
      logic [31:0] tag;
      logic [31:0] target;
   } btb_write_type;

endpackage

`default_nettype wire

// ----- hdl/gpb_btb.sv -----
// ----------------------------------------------------------------------------
// gpb_btb
// Fully associative branch target buffer: lowest-match lookup, allocation
// into the lowest free slot or else at the round-robin replace pointer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gshare_predictor_with_btb_defines.svh"

module gpb_btb
   import gpb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [31:0]    lookup_pc,
   output btb_lookup_type      lookup,
   input  wire btb_write_type  wr
);

   logic [31:0]             tag_ff    [BTB_ENTRIES];
   logic [31:0]             target_ff [BTB_ENTRIES];
   logic [BTB_ENTRIES-1:0]  valid_ff;
   logic [BTB_IDX_BITS-1:0] replace_ptr_ff;
   logic [BTB_IDX_BITS-1:0] replace_ptr_in;

   logic [BTB_IDX_BITS-1:0] free_idx;
   logic [BTB_IDX_BITS-1:0] write_idx;
   logic                    any_free;

   // Scan from the top so that the lowest matching entry wins.
   always_comb begin
      lookup.hit    = 1'b0;
      lookup.target = '0;
      for (int i = BTB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == lookup_pc)) begin
            lookup.hit    = 1'b1;
            lookup.target = target_ff[i];
         end
      end
   end

   always_comb begin
      free_idx = '0;
      for (int i = BTB_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = BTB_IDX_BITS'(i);
         end
      end
      any_free  = ~(&valid_ff);
      write_idx = any_free ? free_idx : replace_ptr_ff;
      if (replace_ptr_ff == BTB_IDX_BITS'(BTB_ENTRIES - 1)) begin
         replace_ptr_in = '0;
      end else begin
         replace_ptr_in = replace_ptr_ff + BTB_IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         replace_ptr_ff <= '0;
      end else if (wr.en) begin
         valid_ff[write_idx] <= 1'b1;
         replace_ptr_ff      <= replace_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tag_ff[write_idx]    <= wr.tag;
         target_ff[write_idx] <= wr.target;
      end
   end

   `GPB_ASSERT_NEXT(a_write_sets_valid, clock, reset, wr.en, valid_ff[$past(write_idx)], "BTB write did not set the valid bit")
   `GPB_ASSERT_NEXT(a_idle_holds_state, clock, reset, !wr.en, $stable(valid_ff) && $stable(replace_ptr_ff), "BTB state changed without a write")
   `GPB_ASSERT_NEXT(a_full_stays_full, clock, reset, &valid_ff, &valid_ff, "BTB lost a valid entry")

endmodule

`default_nettype wire

// ----- hdl/gshare_predictor_with_btb.sv -----
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb
// gshare direction predictor with a fully associative branch target buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data (pc, cond_branch, taken, branch_target)
//   and raise start; a beat is taken at each edge with start high and busy
//   low. busy stays low, so a beat may be offered on every cycle.
//   Response channel: rsp_strobe is high for exactly one cycle with
//   rsp_data (next_pc, predicted_taken, btb_hit); the receiver cannot stall
//   and must take the beat in that cycle.
//   Each request passes through the request register and then the response
//   register; one item per cycle sustained. Each item is looked up and
//   updated between the request register and the response register, so
//   the following item always sees the state this one leaves.
//   Prediction and BTB hit use the state before the item's own update.
//   Reset (synchronous, active high): history and replace pointer clear,
//   every counter goes to weakly not-taken, every BTB entry is invalid,
//   and any beat in flight is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gshare_predictor_with_btb_defines.svh"

module gshare_predictor_with_btb
   import gpb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic                    stage_valid_ff;
   req_type                 stage_req_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_in;

   logic [HISTORY_BITS-1:0] history_ff;
   logic [HISTORY_BITS-1:0] history_in;
   logic [1:0]              pht_ff [PHT_ENTRIES];
   logic [1:0]              ctr_in;
   logic [1:0]              ctr_cur;
   logic [HISTORY_BITS-1:0] slot;
   logic                    pred;
   logic                    update_en;

   btb_lookup_type          lookup;
   btb_write_type           btb_wr;

   assign busy = 1'b0;

   gpb_btb u_btb (
      .clock     (clock),
      .reset     (reset),
      .lookup_pc (stage_req_ff.pc),
      .lookup    (lookup),
      .wr        (btb_wr)
   );

   always_comb begin
      slot      = stage_req_ff.pc[HISTORY_BITS-1:0] ^ history_ff;
      ctr_cur   = pht_ff[slot];
      pred      = (ctr_cur >= CTR_TAKEN_MIN);
      update_en = stage_valid_ff && stage_req_ff.cond_branch;

      // Saturate one step toward the outcome.
      ctr_in = ctr_cur;
      if (stage_req_ff.taken) begin
         if (ctr_cur != CTR_MAX) begin
            ctr_in = ctr_cur + 2'd1;
         end
      end else begin
         if (ctr_cur != CTR_MIN) begin
            ctr_in = ctr_cur - 2'd1;
         end
      end

      if (HISTORY_BITS > 1) begin
         history_in = {history_ff[HISTORY_BITS-2:0], stage_req_ff.taken};
      end else begin
         history_in = HISTORY_BITS'(stage_req_ff.taken);
      end

      btb_wr.en     = update_en && stage_req_ff.taken;
      btb_wr.tag    = stage_req_ff.pc;
      btb_wr.target = stage_req_ff.branch_target;

      rsp_in.predicted_taken = pred;
      rsp_in.btb_hit         = lookup.hit;
      if (pred && stage_req_ff.cond_branch && lookup.hit) begin
         rsp_in.next_pc = lookup.target;
      end else begin
         rsp_in.next_pc = stage_req_ff.pc + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         history_ff     <= '0;
         for (int i = 0; i < PHT_ENTRIES; i++) begin
            pht_ff[i] <= CTR_WEAK_NT;
         end
      end else begin
         stage_valid_ff <= start && !busy;
         rsp_strobe_ff  <= stage_valid_ff;
         if (update_en) begin
            pht_ff[slot] <= ctr_in;
            history_ff   <= history_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         stage_req_ff <= req_data;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `GPB_ASSERT_NEXT(a_stage_gives_beat, clock, reset, stage_valid_ff, rsp_strobe, "accepted item produced no response beat")
   `GPB_ASSERT_NEXT(a_nonbranch_keeps_history, clock, reset, !update_en, $stable(history_ff), "history changed without a branch")
   `GPB_ASSERT_NEXT(a_counter_saturates, clock, reset, update_en && stage_req_ff.taken && (ctr_cur == CTR_MAX), pht_ff[$past(slot)] == CTR_MAX, "taken counter left saturation")

endmodule

`default_nettype wire

// ----- sim/gshare_predictor_with_btb_tb.sv -----
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb_tb
// Self-checking bench for the gshare predictor and its branch target buffer.
// A behavioural copy of the counters, history and target buffer predicts
// each response beat. Directed sequences cover PC wrap, counter saturation,
// duplicate tags and FIFO replacement. Random traffic from a pool of
// recurring branches follows, in bursts with gaps, including a full drain.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb_tb;
   import gpb_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int LIMIT_CYCLES  = 200_000;
   localparam int POOL_SIZE     = 24;
   localparam int PRINT_LIMIT   = 100;
   localparam logic [HISTORY_BITS-1:0] SAT_SLOT = 4'h5;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // behavioural copy of the predictor state
   logic [HISTORY_BITS-1:0] ghist;
   logic [1:0]              pht        [PHT_ENTRIES];
   logic [31:0]             btb_tag    [BTB_ENTRIES];
   logic [31:0]             btb_target [BTB_ENTRIES];
   logic                    btb_valid  [BTB_ENTRIES];
   int                      fifo_ptr;

   rsp_type pending_predictions[$];
   int      mismatch_count = 0;

   // recurring branches for the random traffic
   logic [31:0] pool_pc     [POOL_SIZE];
   logic [31:0] pool_target [POOL_SIZE];
   int          pool_bias   [POOL_SIZE];

   gshare_predictor_with_btb DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   task automatic clear_predictor_state();
      int i;
      ghist    = '0;
      fifo_ptr = 0;
      for (i = 0; i < PHT_ENTRIES; i++) pht[i] = CTR_WEAK_NT;
      for (i = 0; i < BTB_ENTRIES; i++) begin
         btb_tag[i]    = '0;
         btb_target[i] = '0;
         btb_valid[i]  = 1'b0;
      end
   endtask

   // Predict one fetch from the current state, then apply its update.
   function automatic rsp_type predict_fetch(input req_type item);
      logic [HISTORY_BITS-1:0] slot;
      rsp_type                 res;
      int                      i;
      int                      hit_idx;
      int                      wr_idx;
      slot    = item.pc[HISTORY_BITS-1:0] ^ ghist;
      hit_idx = -1;
      for (i = 0; i < BTB_ENTRIES; i++)
         if (hit_idx < 0 && btb_valid[i] && btb_tag[i] == item.pc) hit_idx = i;
      res.predicted_taken = (pht[slot] >= CTR_TAKEN_MIN);
      res.btb_hit         = (hit_idx >= 0);
      if (res.predicted_taken && item.cond_branch && res.btb_hit)
         res.next_pc = btb_target[hit_idx];
      else
         res.next_pc = item.pc + 32'd1;

      if (item.cond_branch) begin
         if (item.taken) begin
            if (pht[slot] != CTR_MAX) pht[slot] = pht[slot] + 2'd1;
         end else if (pht[slot] != CTR_MIN) begin
            pht[slot] = pht[slot] - 2'd1;
         end
         ghist = {ghist[HISTORY_BITS-2:0], item.taken};
         if (item.taken) begin
            // lowest free slot first, else the FIFO slot
            wr_idx = -1;
            for (i = 0; i < BTB_ENTRIES; i++)
               if (wr_idx < 0 && !btb_valid[i]) wr_idx = i;
            if (wr_idx < 0) wr_idx = fifo_ptr;
            btb_tag[wr_idx]    = item.pc;
            btb_target[wr_idx] = item.branch_target;
            btb_valid[wr_idx]  = 1'b1;
            fifo_ptr           = (fifo_ptr + 1) % BTB_ENTRIES;
         end
      end
      return res;
   endfunction

   function automatic req_type make_item(input logic [31:0] pc, input logic cond_branch,
                                         input logic taken, input logic [31:0] target);
      req_type item;
      item.pc            = pc;
      item.cond_branch   = cond_branch;
      item.taken         = taken;
      item.branch_target = target;
      return item;
   endfunction

   function automatic req_type random_item();
      return make_item($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom);
   endfunction

   // PC whose counter index lands on the given slot under the present history
   function automatic logic [31:0] pc_for_slot(input logic [31:0] upper,
                                               input logic [HISTORY_BITS-1:0] slot);
      return {upper[31:HISTORY_BITS], slot ^ ghist};
   endfunction

   task automatic send_item(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      pending_predictions.push_back(predict_fetch(item));
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         start    <= 1'b0;
         req_data <= random_item();
         @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_predictions.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_predictions.size() == 0) begin
            report_mismatch("unexpected beat, next_pc", rsp_data.next_pc, '0);
         end else begin
            want = pending_predictions.pop_front();
            if (rsp_data.next_pc !== want.next_pc)
               report_mismatch("next_pc", rsp_data.next_pc, want.next_pc);
            if (rsp_data.predicted_taken !== want.predicted_taken)
               report_mismatch("predicted_taken", 32'(rsp_data.predicted_taken),
                               32'(want.predicted_taken));
            if (rsp_data.btb_hit !== want.btb_hit)
               report_mismatch("btb_hit", 32'(rsp_data.btb_hit), 32'(want.btb_hit));
         end
      end
   end

   task automatic test_pc_wrap();
      send_item(make_item(32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF));
      send_item(make_item(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000));
   endtask

   // Drive one counter to the bottom and then to the top; the taken beats
   // also fill the first buffer slots.
   task automatic test_counter_saturation();
      int k;
      for (k = 0; k < 2; k++)
         send_item(make_item(pc_for_slot(32'h00A0_0000 + (k << 8), SAT_SLOT),
                             1'b1, 1'b0, $urandom));
      for (k = 0; k < 4; k++)
         send_item(make_item(pc_for_slot(32'h0040_1000 + (k << 8), SAT_SLOT),
                             1'b1, 1'b1, 32'h0050_0000 + k));
   endtask

   // History is all ones now, so a fixed PC keeps hitting the saturated slot.
   task automatic test_duplicate_tags();
      logic [31:0] dup_pc;
      dup_pc = pc_for_slot(32'h8000_0120, SAT_SLOT);
      send_item(make_item(dup_pc, 1'b1, 1'b1, 32'h1111_1110));
      send_item(make_item(dup_pc, 1'b1, 1'b1, 32'h2222_2220));
      send_item(make_item(dup_pc, 1'b1, 1'b1, 32'h3333_3330));
      send_item(make_item(dup_pc, 1'b0, 1'b0, 32'h0000_0000));
   endtask

   task automatic test_btb_replacement();
      logic [31:0] evicted_pc;
      int          k;
      send_item(make_item($urandom, 1'b1, 1'b1, 32'h0000_0000));
      send_item(make_item($urandom, 1'b1, 1'b1, 32'hFFFF_FFFF));
      for (k = 0; k < 7; k++) send_item(make_item($urandom, 1'b1, 1'b1, $urandom));
      // buffer is full: the next write lands on the FIFO slot
      evicted_pc = btb_tag[fifo_ptr];
      send_item(make_item($urandom, 1'b1, 1'b1, $urandom));
      send_item(make_item(evicted_pc, 1'b0, 1'b1, $urandom));
   endtask

   task automatic refill_pool();
      int p;
      for (p = 0; p < POOL_SIZE; p++) begin
         pool_pc[p]     = $urandom;
         pool_target[p] = $urandom;
         case ($urandom_range(0, 2))
            0:       pool_bias[p] = 5;
            1:       pool_bias[p] = 50;
            default: pool_bias[p] = 95;
         endcase
      end
   endtask

   function automatic req_type next_traffic_item(input int span);
      req_type item;
      int      sel;
      int      p;
      sel  = $urandom_range(0, 99);
      p    = $urandom_range(0, span - 1);
      item = random_item();
      if (sel < 70) begin
         item.pc          = pool_pc[p];
         item.cond_branch = 1'b1;
         item.taken       = ($urandom_range(0, 99) < pool_bias[p]);
         if ($urandom_range(0, 9) != 0) item.branch_target = pool_target[p];
      end else if (sel < 85) begin
         if (sel < 78) item.pc = pool_pc[p];
         item.cond_branch = 1'b0;
      end else if (sel >= 97) begin
         item.pc = 32'hFFFF_FFFF - $urandom_range(0, 1);
      end
      return item;
   endfunction

   task automatic test_random_traffic(input int n, input int span);
      int sent;
      int burst;
      int k;
      sent = 0;
      refill_pool();
      while (sent < n) begin
         burst = $urandom_range(1, 32);
         for (k = 0; k < burst && sent < n; k++) begin
            send_item(next_traffic_item(span));
            sent++;
         end
         if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 6));
      end
   endtask

   // Hold the sender until every outstanding beat has returned.
   task automatic test_pause_until_drained();
      wait_for_drain();
      idle_cycles($urandom_range(1, 4));
   endtask

   initial begin
      clear_predictor_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_pc_wrap();
      test_counter_saturation();
      test_duplicate_tags();
      test_btb_replacement();
      test_random_traffic(RANDOM_ITEMS / 2, POOL_SIZE / 2);
      test_pause_until_drained();
      test_random_traffic(RANDOM_ITEMS / 2, POOL_SIZE);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_predictions.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/gpb_pkg.sv
hdl/gpb_btb.sv
hdl/gshare_predictor_with_btb.sv
sim/gshare_predictor_with_btb_tb.sv
